// ===== sv/tbwd_pkg.sv =====
// Shared types, codes and constants of the timer bank with watchdog.
// Used by the front decoder, the item queue, the back end and the top level.
// No dependencies.
package tbwd_pkg;

    // Register map geometry: room for four timers in fixed slots
    localparam int unsigned NUM_SLOTS   = 4;
    localparam int unsigned SLOT_IDX_W  = $clog2(NUM_SLOTS);
    localparam int unsigned SLOT_POS [NUM_SLOTS] = '{0, 1, 2, 5};
    localparam int unsigned WDOG_TIMER  = 3;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned ADDR_W      = 4;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned IRQ_STAT_POS = 16;
    localparam int unsigned WDOG_EN_POS  = 25;

    // Stream packing
    localparam int unsigned S_TDATA_W   = 40;  // address, write_data
    localparam int unsigned S_TUSER_W   = CMD_W;
    localparam int unsigned M_TDATA_W   = 40;  // read_data, timer_irq, wdog_reset

    // Defaults for top-level parameters
    localparam int unsigned DEF_NUM_TIMERS    = 4;
    localparam int unsigned DEF_COUNTER_WIDTH = 32;
    localparam int unsigned QUEUE_DEPTH       = 2;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // Register word offsets
    localparam logic [ADDR_W-1:0] ADDR_CTRL   = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_THRESH = 4'd13;
    localparam logic [ADDR_W-1:0] ADDR_RELOAD = 4'd14;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_READ,
        OP_WRITE,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        TGT_NONE,
        TGT_CTRL,
        TGT_THRESH,
        TGT_RELOAD,
        TGT_LOAD,
        TGT_CUR
    } tgt_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        op_t                   op;
        tgt_t                  tgt;
        logic [SLOT_IDX_W-1:0] idx;
        logic [DATA_W-1:0]     data;
    } item_t;

    typedef struct packed {
        logic                 wdog_reset;
        logic [NUM_SLOTS-1:0] timer_irq;
        logic [DATA_W-1:0]    read_data;
    } result_t;

    // Bit i set when timer i is present
    function automatic logic [NUM_SLOTS-1:0] present_mask(input int unsigned n);
        logic [NUM_SLOTS-1:0] m;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            m[i] = (i < n);
        end
        return m;
    endfunction

endpackage

// ===== sv/tbwd_front.sv =====
// Front end: accepts requests from the input stream and classifies them.
// Depends on tbwd_pkg.
module tbwd_front
    import tbwd_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = DEF_NUM_TIMERS
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output item_t                q_item
);

    localparam logic [NUM_SLOTS-1:0] Present     = present_mask(NUM_TIMERS);
    localparam logic                 WdogPresent = Present[WDOG_TIMER];

    logic [ADDR_W-1:0] address;

    assign address  = s_tdata[ADDR_W-1:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.data = s_tdata[ADDR_W +: DATA_W];
        q_item.idx  = '0;
        q_item.tgt  = TGT_NONE;

        unique case (s_tuser)
            CMD_TICK:  q_item.op = OP_TICK;
            CMD_READ:  q_item.op = OP_READ;
            CMD_WRITE: q_item.op = OP_WRITE;
            default:   q_item.op = OP_NOP;
        endcase

        // Map the word offset onto a register; absent timers map to nothing
        if (address == ADDR_CTRL) begin
            q_item.tgt = TGT_CTRL;
        end else if (address == ADDR_THRESH) begin
            q_item.tgt = TGT_THRESH;
        end else if (address == ADDR_RELOAD) begin
            q_item.tgt = WdogPresent ? TGT_RELOAD : TGT_NONE;
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (Present[i] && address == ADDR_W'(1 + 2 * SLOT_POS[i])) begin
                    q_item.tgt = TGT_LOAD;
                    q_item.idx = SLOT_IDX_W'(i);
                end
                if (Present[i] && address == ADDR_W'(2 + 2 * SLOT_POS[i])) begin
                    q_item.tgt = TGT_CUR;
                    q_item.idx = SLOT_IDX_W'(i);
                end
            end
        end
    end

endmodule

// ===== sv/tbwd_queue.sv =====
// Short FIFO of classified requests between the front and the back end.
// Depends on tbwd_pkg.
module tbwd_queue
    import tbwd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == CntW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/tbwd_back.sv =====
// Back end: holds the timer state, carries out ticks, reads and writes,
// and registers one result per request. Depends on tbwd_pkg.
module tbwd_back
    import tbwd_pkg::*;
#(
    parameter int unsigned NUM_TIMERS    = DEF_NUM_TIMERS,
    parameter int unsigned COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    localparam logic [NUM_SLOTS-1:0] Present     = present_mask(NUM_TIMERS);
    localparam logic                 WdogPresent = Present[WDOG_TIMER];

    logic [NUM_SLOTS-1:0]     enable_reg, enable_next;
    logic                     wdog_en_reg, wdog_en_next;
    logic [NUM_SLOTS-1:0]     irq_reg, irq_next;
    logic [COUNTER_WIDTH-1:0] load_reg [NUM_SLOTS];
    logic [COUNTER_WIDTH-1:0] load_next [NUM_SLOTS];
    logic [COUNTER_WIDTH-1:0] cnt_reg [NUM_SLOTS];
    logic [COUNTER_WIDTH-1:0] cnt_next [NUM_SLOTS];
    logic [COUNTER_WIDTH-1:0] thresh_reg, thresh_next;
    logic [COUNTER_WIDTH-1:0] cnt_dec [NUM_SLOTS];
    logic [COUNTER_WIDTH-1:0] elapsed [NUM_SLOTS];
    logic [DATA_W-1:0]        ctrl_word;
    logic [DATA_W-1:0]        rd_data;
    logic                     rst_pulse;
    logic                     wd_mode;
    logic                     exec;
    logic                     res_valid_reg;
    result_t                  res_reg;

    // Take a new request whenever the result register is free or draining
    assign exec      = q_valid && (!res_valid_reg || res_ready);
    assign q_pop     = exec;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign wd_mode   = WdogPresent && wdog_en_reg && enable_reg[WDOG_TIMER];

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            cnt_dec[i] = cnt_reg[i] - COUNTER_WIDTH'(1);
            elapsed[i] = load_reg[i] - cnt_dec[i];
        end
    end

    always_comb begin
        ctrl_word = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            ctrl_word[SLOT_POS[i]]                = enable_reg[i] && Present[i];
            ctrl_word[IRQ_STAT_POS + SLOT_POS[i]] = irq_reg[i] && Present[i];
        end
        ctrl_word[WDOG_EN_POS] = wdog_en_reg && WdogPresent;
    end

    always_comb begin
        enable_next  = enable_reg;
        wdog_en_next = wdog_en_reg;
        irq_next     = irq_reg;
        thresh_next  = thresh_reg;
        load_next    = load_reg;
        cnt_next     = cnt_reg;
        rd_data      = '0;
        rst_pulse    = 1'b0;

        unique case (q_item.op)
            OP_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (Present[i] && enable_reg[i]) begin
                        if (cnt_reg[i] == '0) begin
                            // reload; the watchdog fires reset instead of status
                            cnt_next[i] = load_reg[i];
                            if (wd_mode && i == WDOG_TIMER) begin
                                rst_pulse = 1'b1;
                            end else begin
                                irq_next[i] = 1'b1;
                            end
                        end else begin
                            cnt_next[i] = cnt_dec[i];
                            if (wd_mode && i == WDOG_TIMER && elapsed[i] == thresh_reg) begin
                                irq_next[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                unique case (q_item.tgt)
                    TGT_CTRL:   rd_data = ctrl_word;
                    TGT_THRESH: rd_data = DATA_W'(thresh_reg);
                    TGT_LOAD:   rd_data = DATA_W'(load_reg[q_item.idx]);
                    TGT_CUR:    rd_data = DATA_W'(cnt_reg[q_item.idx]);
                    default:    rd_data = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (q_item.tgt)
                    TGT_CTRL: begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            enable_next[i] = q_item.data[SLOT_POS[i]] && Present[i];
                            if (q_item.data[IRQ_STAT_POS + SLOT_POS[i]]) begin
                                irq_next[i] = 1'b0;
                            end
                        end
                        wdog_en_next = q_item.data[WDOG_EN_POS] && WdogPresent;
                    end
                    TGT_THRESH: thresh_next = q_item.data[COUNTER_WIDTH-1:0];
                    TGT_RELOAD: cnt_next[WDOG_TIMER] = load_reg[WDOG_TIMER];
                    TGT_LOAD:   load_next[q_item.idx] = q_item.data[COUNTER_WIDTH-1:0];
                    TGT_CUR:    cnt_next[q_item.idx] = q_item.data[COUNTER_WIDTH-1:0];
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= '0;
            wdog_en_reg <= 1'b0;
            irq_reg     <= '0;
            thresh_reg  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                load_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else if (exec) begin
            enable_reg  <= enable_next;
            wdog_en_reg <= wdog_en_next;
            irq_reg     <= irq_next;
            thresh_reg  <= thresh_next;
            load_reg    <= load_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (exec) begin
            res_valid_reg <= 1'b1;
        end else if (res_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            res_reg.read_data  <= rd_data;
            res_reg.timer_irq  <= irq_next;
            res_reg.wdog_reset <= rst_pulse;
        end
    end

endmodule

// ===== sv/timer_bank_with_watchdog_core.sv =====
// Top level of the timer bank with watchdog: four reloading down-counters,
// the fourth with a watchdog mode. Depends on tbwd_pkg, tbwd_front,
// tbwd_queue and tbwd_back.
//
//   Channel | Direction | Handshake           | Contents
//   --------+-----------+---------------------+---------------------------------------
//   s_      | in        | s_tvalid / s_tready | tuser: command; tdata: address, data
//   m_      | out       | m_tvalid / m_tready | tdata: read_data, timer_irq, wdog_reset
//
// Throughput is one request per cycle while the m_ side takes results; the back
// end executes every request against the register state.
// An accepted request is written into the request queue, then executed from the
// queue into the result register, which drives m_tvalid and m_tdata.
// Reset (aresetn low at a clock edge) clears all timer state to zero;
// no clearing pass follows, and the block takes requests on the next cycle.
// A stalled m_ side fills the result register, then the queue (two entries);
// s_tready drops only when the queue is full.
module timer_bank_with_watchdog_core
    import tbwd_pkg::*;
#(
    parameter int unsigned NUM_TIMERS    = DEF_NUM_TIMERS,     // 1..8, slots 0..3 used
    parameter int unsigned COUNTER_WIDTH = DEF_COUNTER_WIDTH   // 8..32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [3:0] address, [35:4] write_data, [39:36] zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] command
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] read_data, [35:32] timer_irq,
                                            // [36] wdog_reset, [39:37] zero
);

    logic    q_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    item_t   front_item;
    item_t   back_item;
    result_t res;

    // Classify each request as it arrives
    tbwd_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (front_item)
    );

    // Hold classified requests until the back end takes them
    tbwd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_item  (back_item),
        .pop       (q_pop)
    );

    // Execute against the timer state and register the result
    tbwd_back #(
        .NUM_TIMERS    (NUM_TIMERS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (back_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    // Pack the result, pad to whole bytes
    assign m_tdata = M_TDATA_W'({res.wdog_reset, res.timer_irq, res.read_data});

endmodule

// ===== sv/tbwd_checker.sv =====
// Port-level checks on the timer bank with watchdog, bound to the top level.
// Depends on tbwd_pkg and timer_bank_with_watchdog_core.
module tbwd_checker
    import tbwd_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = DEF_NUM_TIMERS
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Hold a waiting request unchanged until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable({s_tuser, s_tdata}))
        else $error("request changed while waiting");

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drop the result channel after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Pulse the watchdog reset only on ticks, which return no read data
    a_wdog_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[36] |-> m_tdata[31:0] == 32'd0)
        else $error("watchdog reset together with read data");

    // Keep status of absent timers and padding at zero
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:32] >> NUM_TIMERS) == 4'd0 && m_tdata[39:37] == 3'd0)
        else $error("status of absent timer or padding set");

endmodule

bind timer_bank_with_watchdog_core tbwd_checker #(
    .NUM_TIMERS (NUM_TIMERS)
) u_tbwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_timer_bank_with_watchdog_core.sv =====
// Testbench for timer_bank_with_watchdog_core: directed and random register traffic
// checked against an in-bench predictor of the timer bank, under varied stream idling.
// Depends on tbwd_pkg and the timer_bank_with_watchdog_core RTL.
`timescale 1ns / 100ps

module tb_timer_bank_with_watchdog_core;
    import tbwd_pkg::*;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
    localparam int SETTLE_CYCLES = 8;     // lets any stray result come out before the verdict
    localparam int PHASE_ITEMS   = 265;

    // Command 3 is not decoded by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Load and current-value registers of the four timers, plus two unmapped holes
    localparam logic [ADDR_W-1:0] REG_LOAD0 = 4'd1;
    localparam logic [ADDR_W-1:0] REG_CUR0  = 4'd2;
    localparam logic [ADDR_W-1:0] REG_LOAD1 = 4'd3;
    localparam logic [ADDR_W-1:0] REG_CUR1  = 4'd4;
    localparam logic [ADDR_W-1:0] REG_LOAD2 = 4'd5;
    localparam logic [ADDR_W-1:0] REG_CUR2  = 4'd6;
    localparam logic [ADDR_W-1:0] REG_HOLE  = 4'd7;
    localparam logic [ADDR_W-1:0] REG_LOAD3 = 4'd11;
    localparam logic [ADDR_W-1:0] REG_CUR3  = 4'd12;
    localparam logic [ADDR_W-1:0] REG_TOP   = 4'd15;

    // Timers 0..2 sit at control bits 0..2; timer 3 sits at bit 5
    localparam int SLOT3_POS = 5;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } bus_req_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [3:0] address, [35:4] write_data, [39:36] zero
    logic [S_TUSER_W-1:0] s_tuser;   // [1:0] command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [31:0] read_data, [35:32] timer_irq,
                                     // [36] wdog_reset, [39:37] zero

    // Requests waiting for the driver, and predicted results waiting for the monitor
    bus_req_t pending_reqs [$];
    result_t  pred_results [$];

    // Predicted register state of the timer bank
    logic [NUM_SLOTS-1:0] tmr_on;
    logic                 wdog_en;
    logic [NUM_SLOTS-1:0] pend_irq;
    logic [DATA_W-1:0]    load_val  [NUM_SLOTS];
    logic [DATA_W-1:0]    count_val [NUM_SLOTS];
    logic [DATA_W-1:0]    wdog_thresh;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  queued;        // requests queued that the block decodes
    int  fail_count;
    int  stall_cycles;
    bit  req_taken;     // the request on s_ was accepted at the last rising edge

    timer_bank_with_watchdog_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #CLK_HIGH;
        aclk = 1'b0;
        #CLK_LOW;
    end

    // Apply one request to the predicted state and return the result it should produce.
    function automatic result_t predict_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                                logic [DATA_W-1:0] data);
        result_t res;
        int      t;
        logic    is_cur;
        logic    wd_mode;
        res    = '0;
        t      = -1;
        is_cur = 1'b0;
        case (addr)
            REG_LOAD0: t = 0;
            REG_CUR0:  begin t = 0; is_cur = 1'b1; end
            REG_LOAD1: t = 1;
            REG_CUR1:  begin t = 1; is_cur = 1'b1; end
            REG_LOAD2: t = 2;
            REG_CUR2:  begin t = 2; is_cur = 1'b1; end
            REG_LOAD3: t = 3;
            REG_CUR3:  begin t = 3; is_cur = 1'b1; end
            default:   t = -1;
        endcase
        case (cmd)
            CMD_TICK: begin
                // Watchdog mode needs both the watchdog enable and timer 3's enable
                wd_mode = wdog_en && tmr_on[WDOG_TIMER];
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tmr_on[i]) begin
                        if (count_val[i] == '0) begin
                            count_val[i] = load_val[i];
                            if (wd_mode && i == WDOG_TIMER) res.wdog_reset = 1'b1;
                            else pend_irq[i] = 1'b1;
                        end else begin
                            count_val[i] = count_val[i] - 1'b1;
                            // Early warning: elapsed ticks since reload hit the threshold
                            if (wd_mode && i == WDOG_TIMER &&
                                load_val[i] - count_val[i] == wdog_thresh)
                                pend_irq[i] = 1'b1;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (addr == ADDR_CTRL) begin
                    res.read_data[2:0]                       = tmr_on[2:0];
                    res.read_data[SLOT3_POS]                 = tmr_on[3];
                    res.read_data[IRQ_STAT_POS +: 3]         = pend_irq[2:0];
                    res.read_data[IRQ_STAT_POS + SLOT3_POS]  = pend_irq[3];
                    res.read_data[WDOG_EN_POS]               = wdog_en;
                end else if (addr == ADDR_THRESH) begin
                    res.read_data = wdog_thresh;
                end else if (t >= 0) begin
                    res.read_data = is_cur ? count_val[t] : load_val[t];
                end
            end
            CMD_WRITE: begin
                if (addr == ADDR_CTRL) begin
                    // Status bits are write-one-to-clear
                    pend_irq = pend_irq & ~{data[IRQ_STAT_POS + SLOT3_POS],
                                            data[IRQ_STAT_POS +: 3]};
                    tmr_on   = {data[SLOT3_POS], data[2:0]};
                    wdog_en  = data[WDOG_EN_POS];
                end else if (addr == ADDR_THRESH) begin
                    wdog_thresh = data;
                end else if (addr == ADDR_RELOAD) begin
                    count_val[WDOG_TIMER] = load_val[WDOG_TIMER];
                end else if (t >= 0) begin
                    if (is_cur) count_val[t] = data;
                    else load_val[t] = data;
                end
            end
            default: ;
        endcase
        res.timer_irq = pend_irq;
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] timer_reg_addr(int k, bit cur);
        case (k)
            0:       return cur ? REG_CUR0 : REG_LOAD0;
            1:       return cur ? REG_CUR1 : REG_LOAD1;
            2:       return cur ? REG_CUR2 : REG_LOAD2;
            default: return cur ? REG_CUR3 : REG_LOAD3;
        endcase
    endfunction

    // Mostly short counts so timers expire often; now and then a full-range value.
    function automatic logic [DATA_W-1:0] count_value();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $urandom_range(0, 12);
    endfunction

    task automatic add_req(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] data);
        bus_req_t r;
        r.cmd  = cmd;
        r.addr = addr;
        r.data = data;
        pending_reqs.push_back(r);
        if (cmd != CMD_UNUSED) queued++;
    endtask

    // Extremes of the fields, every command, watchdog expiry and early warning,
    // reload, unmapped offsets and the status clear.
    task automatic add_directed();
        add_req(CMD_READ,   ADDR_CTRL,   '0);            // reset contents
        add_req(CMD_TICK,   ADDR_CTRL,   '1);            // tick with every timer off
        add_req(CMD_WRITE,  REG_LOAD0,   32'hFFFF_FFFF);
        add_req(CMD_READ,   REG_LOAD0,   '0);
        add_req(CMD_WRITE,  REG_LOAD3,   32'd3);
        add_req(CMD_WRITE,  ADDR_THRESH, 32'd2);
        add_req(CMD_WRITE,  ADDR_CTRL,   32'hFFFF_FFFF); // all timers on, watchdog mode
        add_req(CMD_READ,   ADDR_CTRL,   '0);
        // All counters at zero: timers 0..2 reload and flag, timer 3 pulses reset
        add_req(CMD_TICK,   ADDR_CTRL,   '0);
        repeat (3) add_req(CMD_TICK, ADDR_CTRL, '0);    // elapsed reaches the threshold
        add_req(CMD_READ,   REG_CUR0,    '0);
        add_req(CMD_READ,   REG_CUR3,    '0);
        add_req(CMD_READ,   ADDR_THRESH, '0);
        add_req(CMD_WRITE,  ADDR_RELOAD, 32'hFFFF_FFFF); // restart the watchdog count
        add_req(CMD_READ,   REG_CUR3,    '0);
        add_req(CMD_READ,   ADDR_RELOAD, '0);
        add_req(CMD_WRITE,  REG_HOLE,    32'hFFFF_FFFF);
        add_req(CMD_READ,   REG_HOLE,    '0);
        add_req(CMD_READ,   REG_TOP,     '0);
        add_req(CMD_UNUSED, ADDR_CTRL,   32'hFFFF_FFFF);
        add_req(CMD_WRITE,  ADDR_CTRL,   32'h0027_0000); // clear all status, stop all
        add_req(CMD_READ,   ADDR_CTRL,   '0);
        add_req(CMD_WRITE,  ADDR_CTRL,   32'h0000_0020); // timer 3 alone, plain mode
        repeat (2) add_req(CMD_TICK, ADDR_CTRL, '0);
    endtask

    // Program loads, counts and threshold with short values, enable a random mix,
    // then mostly tick with reads, reloads and rewrites sprinkled in.
    task automatic add_timer_scenario();
        for (int k = 0; k < NUM_SLOTS; k++) begin
            add_req(CMD_WRITE, timer_reg_addr(k, 1'b0), count_value());
            if ($urandom_range(0, 1)) add_req(CMD_WRITE, timer_reg_addr(k, 1'b1), count_value());
        end
        if ($urandom_range(0, 1)) add_req(CMD_WRITE, ADDR_THRESH, $urandom_range(0, 8));
        add_req(CMD_WRITE, ADDR_CTRL, $urandom);
        repeat ($urandom_range(10, 40)) begin
            case ($urandom_range(0, 19))
                13, 14, 15: add_req(CMD_READ, ADDR_W'($urandom_range(0, 15)), $urandom);
                16:         add_req(CMD_WRITE, ADDR_RELOAD, $urandom);
                17:         add_req(CMD_WRITE, ADDR_CTRL, $urandom);
                18:         add_req(CMD_WRITE, timer_reg_addr($urandom_range(0, 3), 1'b1),
                                    count_value());
                19:         add_req(CMD_WRITE, ADDR_THRESH, $urandom_range(0, 8));
                default:    add_req(CMD_TICK, ADDR_W'($urandom_range(0, 15)), $urandom);
            endcase
        end
    endtask

    task automatic add_random(int target);
        int start;
        start = queued;
        while (queued - start < target) begin
            if ($urandom_range(0, 9) < 7) begin
                add_timer_scenario();
            end else begin
                // Noise: any command, offset and data
                repeat ($urandom_range(3, 12))
                    add_req(CMD_W'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 15)),
                            $urandom);
            end
        end
    endtask

    // Driver: change inputs on the falling edge. Hold a request until accepted,
    // then advance to the next one or idle.
    always @(negedge aclk) begin : drive_requests
        bus_req_t r;
        if (aresetn) begin
            if (!s_tvalid || req_taken) begin
                req_taken = 1'b0;
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.cmd;
                    s_tdata  <= {4'b0, r.data, r.addr};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: sample both channels on the rising edge. Predict each accepted
    // request, check each accepted result against the oldest prediction, and
    // end the run when no handshake happens for too long.
    always @(posedge aclk) begin : watch_channels
        result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred_results.push_back(predict_request(s_tuser, s_tdata[ADDR_W-1:0],
                                                       s_tdata[ADDR_W +: DATA_W]));
                req_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (pred_results.size() == 0) begin
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = pred_results.pop_front();
                    if (m_tdata[DATA_W-1:0] !== want.read_data) begin
                        $display("%0t: read_data mismatch: expected %h, actual %h",
                                 $time, want.read_data, m_tdata[DATA_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[DATA_W +: NUM_SLOTS] !== want.timer_irq) begin
                        $display("%0t: timer_irq mismatch: expected %b, actual %b",
                                 $time, want.timer_irq, m_tdata[DATA_W +: NUM_SLOTS]);
                        fail_count++;
                    end
                    if (m_tdata[DATA_W + NUM_SLOTS] !== want.wdog_reset) begin
                        $display("%0t: wdog_reset mismatch: expected %b, actual %b",
                                 $time, want.wdog_reset, m_tdata[DATA_W + NUM_SLOTS]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                             $time, stall_cycles, pred_results.size());
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Stimulus: reset once, then four idling phases. Between phases hold the
    // sender back until every predicted result has come out.
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_TICK;
        m_tready       = 1'b0;
        tmr_on         = '0;
        wdog_en        = 1'b0;
        pend_irq       = '0;
        wdog_thresh    = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            load_val[i]  = '0;
            count_val[i] = '0;
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queued         = 0;
        fail_count     = 0;
        stall_cycles   = 0;
        req_taken      = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (phase == 0) add_directed();
            add_random(PHASE_ITEMS);
            while (pending_reqs.size() != 0 || s_tvalid || pred_results.size() != 0)
                @(posedge aclk);
        end

        // Let any stray result surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tbwd_pkg.sv
sv/tbwd_front.sv
sv/tbwd_queue.sv
sv/tbwd_back.sv
sv/timer_bank_with_watchdog_core.sv
sv/tbwd_checker.sv
test/tb_timer_bank_with_watchdog_core.sv
